/* sv/dte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited text extractor package
// Shared widths, register codes, configuration and result types, and the
// marker window compare used by the extractor engine.
// ----------------------------------------------------------------------------
package dte_pkg;

  localparam int MaxMarkerBytes = 8;
  localparam int MarkerW        = 8 * MaxMarkerBytes;
  localparam int LenW           = 4;
  localparam int LaneIdxW       = $clog2(MaxMarkerBytes);
  localparam int CountW         = 16;
  localparam int CfgDataW       = 64;
  localparam int CfgIdxW        = 2;
  localparam int QueueDepth     = 2;
  localparam int QueuePtrW      = $clog2(QueueDepth);
  localparam int QueueCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    REG_BEGIN_MARKER = 2'd0,
    REG_BEGIN_LENGTH = 2'd1,
    REG_END_MARKER   = 2'd2,
    REG_END_LENGTH   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [MarkerW-1:0] begin_marker;
    logic [LenW-1:0]    begin_length;
    logic [MarkerW-1:0] end_marker;
    logic [LenW-1:0]    end_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        content_byte;
    logic              content_valid;
    logic              done_res;
    logic [CountW-1:0] content_length;
  } res_t;

  // A length of zero acts as one; anything above the window acts as the window.
  function automatic logic [LenW-1:0] clamp_len(logic [LenW-1:0] len);
    logic [LenW-1:0] res;
    if (len == '0) begin
      res = LenW'(1);
    end else if (len > LenW'(MaxMarkerBytes)) begin
      res = LenW'(MaxMarkerBytes);
    end else begin
      res = len;
    end
    return res;
  endfunction

  // The window holds the newest byte in lane 0; the marker holds its first
  // byte in lane 0.
  function automatic logic win_match(logic [MarkerW-1:0] win, logic [MarkerW-1:0] mark,
                                     logic [LenW-1:0] len);
    logic                ok;
    logic [LaneIdxW-1:0] idx;
    ok = 1'b1;
    for (int k = 0; k < MaxMarkerBytes; k++) begin
      idx = LaneIdxW'(len - LenW'(1) - LenW'(k));
      if ((LenW'(k) < len) && (win[8*idx +: 8] != mark[8*k +: 8])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

/* sv/dte_in_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited text extractor input queue
// Accepts stream bytes and holds them for the engine, so that the input side
// stalls only when the queue is full.
// ----------------------------------------------------------------------------
module dte_in_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_stall_o,
  input  logic [7:0] push_byte_i,
  output logic       pop_valid_o,
  input  logic       pop_i,
  output logic [7:0] pop_byte_o
);
  import dte_pkg::*;

  logic [7:0]           mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 push;
  logic                 pop;

  assign push_stall_o = (cnt_q == QueueCntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_byte_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueuePtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueuePtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QueueCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_byte_i;
    end
  end

endmodule

/* sv/dte_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited text extractor engine
// Runs the begin search and the end-marker delay window on one byte per cycle
// while not stalled, and keeps each result in an output register until taken.
// ----------------------------------------------------------------------------
module dte_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dte_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  input  logic [7:0]     item_byte_i,
  output logic           item_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dte_pkg::res_t  res_o
);
  import dte_pkg::*;

  logic               capturing_q, capturing_d;
  logic [MarkerW-1:0] begin_win_q, begin_win_d;
  logic [MarkerW-1:0] end_win_q, end_win_d;
  logic [LenW-1:0]    fill_q, fill_d;
  logic [CountW-1:0]  count_q, count_d;
  logic               out_valid_q, out_valid_d;
  res_t               res_q, res_d;

  logic [LenW-1:0]     lb;
  logic [LenW-1:0]     le;
  logic [LaneIdxW-1:0] emit_idx;
  logic [MarkerW-1:0]  end_shift;
  logic                emit;
  logic                done;

  assign lb         = clamp_len(cfg_i.begin_length);
  assign le         = clamp_len(cfg_i.end_length);
  assign emit_idx   = LaneIdxW'(le - LenW'(1));
  assign end_shift  = {end_win_q[MarkerW-9:0], item_byte_i};
  assign item_pop_o = item_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    capturing_d = capturing_q;
    begin_win_d = begin_win_q;
    end_win_d   = end_win_q;
    fill_d      = fill_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    emit        = 1'b0;
    done        = 1'b0;
    if (item_pop_o) begin
      if (!capturing_q) begin
        if (win_match(begin_win_q, cfg_i.begin_marker, lb)) begin
          capturing_d = 1'b1;
          end_win_d   = {{(MarkerW-8){1'b0}}, item_byte_i};
          fill_d      = LenW'(1);
          count_d     = '0;
        end
        begin_win_d = {begin_win_q[MarkerW-9:0], item_byte_i};
      end else if (fill_q < le) begin
        end_win_d = end_shift;
        fill_d    = fill_q + LenW'(1);
      end else begin
        emit      = 1'b1;
        end_win_d = end_shift;
        if (fill_q < LenW'(MaxMarkerBytes)) begin
          fill_d = fill_q + LenW'(1);
        end
        if (count_q != '1) begin
          count_d = count_q + CountW'(1);
        end
        done = win_match(end_shift, cfg_i.end_marker, le);
        res_d.content_byte   = end_win_q[8*emit_idx +: 8];
        res_d.content_valid  = 1'b1;
        res_d.done_res       = done;
        res_d.content_length = done ? count_d : '0;
        out_valid_d          = 1'b1;
        if (done) begin
          capturing_d = 1'b0;
          begin_win_d = '0;
          end_win_d   = '0;
          fill_d      = '0;
          count_d     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q <= 1'b0;
      begin_win_q <= '0;
      end_win_q   <= '0;
      fill_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      capturing_q <= capturing_d;
      begin_win_q <= begin_win_d;
      end_win_q   <= end_win_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

endmodule

/* sv/delimited_text_extractor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited text extractor
// Pulls the bytes found between a begin marker and an end marker out of a
// byte stream and reports the content length when the end marker completes.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         in_valid_i / in_stall_o   data_byte_i
//   output    out        out_valid_o / out_stall_i content_byte_o, content_valid_o,
//                                                  done_res_o, content_length_o
//   config    in         cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// One byte is taken per cycle while nothing stalls; each byte passes through
// the input queue into the engine, which registers any result.
// A two-entry input queue feeds the engine, whose window compares are
// combinational; the result sits in an output register.
// An output stall holds the output register; the queue then fills and the
// input side stalls after at most two more transfers.
// Reset is asynchronous and active low and needs no clearing pass.
// ----------------------------------------------------------------------------
module delimited_text_extractor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      data_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      content_byte_o,
  output logic                            content_valid_o,
  output logic                            done_res_o,
  output logic [dte_pkg::CountW-1:0]      content_length_o,
  input  logic                            cfg_we_i,
  input  logic [dte_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [dte_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import dte_pkg::*;

  cfg_t       cfg_q;
  res_t       res;
  logic       q_valid;
  logic       q_pop;
  logic [7:0] q_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.begin_marker <= '0;
      cfg_q.begin_length <= LenW'(1);
      cfg_q.end_marker   <= '0;
      cfg_q.end_length   <= LenW'(1);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_BEGIN_MARKER: cfg_q.begin_marker <= cfg_wdata_i[MarkerW-1:0];
        REG_BEGIN_LENGTH: cfg_q.begin_length <= cfg_wdata_i[LenW-1:0];
        REG_END_MARKER:   cfg_q.end_marker   <= cfg_wdata_i[MarkerW-1:0];
        REG_END_LENGTH:   cfg_q.end_length   <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  dte_in_queue u_in_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_byte_i  (data_byte_i),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_byte_o   (q_byte)
  );

  dte_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_byte_i  (q_byte),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  assign content_byte_o   = res.content_byte;
  assign content_valid_o  = res.content_valid;
  assign done_res_o       = res.done_res;
  assign content_length_o = res.content_length;

endmodule

/* sv/dte_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited text extractor checker
// Port-level checks on the result channel, attached to the top level.
// ----------------------------------------------------------------------------
module dte_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [7:0]                   content_byte_o,
  input logic                         content_valid_o,
  input logic                         done_res_o,
  input logic [dte_pkg::CountW-1:0]   content_length_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(content_byte_o)
      && $stable(done_res_o) && $stable(content_length_o))
    else $error("stalled result changed");

  a_valid_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> content_valid_o)
    else $error("result without content flag");

  a_done_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> content_length_o != '0)
    else $error("done with zero length");

  a_len_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> content_length_o == '0)
    else $error("length reported without done");

endmodule

bind delimited_text_extractor dte_checker u_dte_checker (.*);
